// ===== design/utf8dec_pkg.sv =====
package utf8dec_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned CodeWidth    = 31;
   localparam int unsigned PendingWidth = 3;
   localparam int unsigned TailBits     = 6;

   // Following bytes expected after each kind of lead byte
   localparam logic [PendingWidth-1:0] NEED_TWO_BYTE   = 3'd1;
   localparam logic [PendingWidth-1:0] NEED_THREE_BYTE = 3'd2;
   localparam logic [PendingWidth-1:0] NEED_FOUR_BYTE  = 3'd3;
   localparam logic [PendingWidth-1:0] NEED_FIVE_BYTE  = 3'd4;
   localparam logic [PendingWidth-1:0] NEED_SIX_BYTE   = 3'd5;
   localparam logic [PendingWidth-1:0] NEED_NONE       = 3'd0;

   typedef struct packed {
      logic [ByteWidth-1:0] byte_in;
      logic                 last_byte;
   } utf8dec_req_type;

   typedef struct packed {
      logic [CodeWidth-1:0] code_point;
      logic                 bad_sequence;
      logic                 end_of_string;
   } utf8dec_rsp_type;

   typedef struct packed {
      logic [PendingWidth-1:0] bytes_pending;
      logic [CodeWidth-1:0]    partial_value;
   } utf8dec_state_type;

endpackage

// ===== design/utf8dec_step.sv =====
module utf8dec_step
   import utf8dec_pkg::*;
(
   input  utf8dec_state_type cur_state,
   input  utf8dec_req_type   beat,
   output utf8dec_state_type next_state,
   output logic              emit,
   output utf8dec_rsp_type   result
);

   logic [ByteWidth-1:0]    b;
   logic [PendingWidth-1:0] need;
   logic [PendingWidth-1:0] pend_dec;
   logic [CodeWidth-1:0]    lead_payload;
   logic [CodeWidth-1:0]    acc;
   logic                    lead_ok;
   logic                    lead_ascii;

   assign b        = beat.byte_in;
   assign acc      = {cur_state.partial_value[CodeWidth-TailBits-1:0], b[TailBits-1:0]};
   assign pend_dec = cur_state.bytes_pending - 3'd1;

   // lead byte classification
   always_comb begin
      need         = NEED_NONE;
      lead_payload = '0;
      lead_ok      = 1'b1;
      lead_ascii   = 1'b0;
      unique case (b) inside
         8'b0???????: begin
            lead_ascii = 1'b1;
         end
         8'b110?????: begin
            need         = NEED_TWO_BYTE;
            lead_payload = {26'd0, b[4:0]};
         end
         8'b1110????: begin
            need         = NEED_THREE_BYTE;
            lead_payload = {27'd0, b[3:0]};
         end
         8'b11110???: begin
            need         = NEED_FOUR_BYTE;
            lead_payload = {28'd0, b[2:0]};
         end
         8'b111110??: begin
            need         = NEED_FIVE_BYTE;
            lead_payload = {29'd0, b[1:0]};
         end
         8'b1111110?: begin
            need         = NEED_SIX_BYTE;
            lead_payload = {30'd0, b[0]};
         end
         default: begin
            lead_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      next_state = cur_state;
      emit       = 1'b0;
      result     = '0;
      if (cur_state.bytes_pending == NEED_NONE) begin
         if (lead_ascii) begin
            emit                 = 1'b1;
            result.code_point    = {23'd0, b};
            result.end_of_string = beat.last_byte;
            next_state           = '0;
         end else if (!lead_ok) begin
            emit                 = 1'b1;
            result.bad_sequence  = 1'b1;
            result.end_of_string = beat.last_byte;
            next_state           = '0;
         end else if (beat.last_byte) begin
            // multi-byte lead that ends the string
            emit                 = 1'b1;
            result.bad_sequence  = 1'b1;
            result.end_of_string = 1'b1;
            next_state           = '0;
         end else begin
            next_state.bytes_pending = need;
            next_state.partial_value = lead_payload;
         end
      end else begin
         if (pend_dec == NEED_NONE) begin
            emit                 = 1'b1;
            result.code_point    = acc;
            result.end_of_string = beat.last_byte;
            next_state           = '0;
         end else if (beat.last_byte) begin
            // string ends inside a sequence
            emit                 = 1'b1;
            result.bad_sequence  = 1'b1;
            result.end_of_string = 1'b1;
            next_state           = '0;
         end else begin
            next_state.bytes_pending = pend_dec;
            next_state.partial_value = acc;
         end
      end
   end

endmodule

// ===== design/utf8_to_code_point_decoder_unit.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_beat: byte_in, last_byte
// rsp       out        rsp_valid/rsp_stall  rsp_beat: code_point, bad_sequence, end_of_string
//
// One byte beat per cycle sustained while the sink does not stall; the last byte
// of a result passes the input register, then the result register.
// The decode state (pending count, partial value) is a register fed from the step
// logic, so the state loop through the step logic sets the one-byte-per-cycle rate.
// Reset (synchronous) empties both registers and clears the decode state.
// req_stall rises only when the input register holds a byte and the result
// register holds a beat that the sink is stalling.
module utf8_to_code_point_decoder_unit
   import utf8dec_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  utf8dec_req_type req_beat,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output utf8dec_rsp_type rsp_beat
);

   // input register
   logic              in_valid_ff, in_valid_in;
   utf8dec_req_type   in_beat_ff, in_beat_in;
   // result register
   logic              out_valid_ff, out_valid_in;
   utf8dec_rsp_type   out_beat_ff, out_beat_in;
   // decode state
   utf8dec_state_type state_ff, state_in;

   utf8dec_state_type step_state;
   logic              step_emit;
   utf8dec_rsp_type   step_result;

   logic req_take;   // byte beat accepted this cycle
   logic out_load;   // result register free to load
   logic fire;       // buffered byte is processed this cycle

   utf8dec_step u_step (
      .cur_state  (state_ff),
      .beat       (in_beat_ff),
      .next_state (step_state),
      .emit       (step_emit),
      .result     (step_result)
   );

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !fire);
      in_beat_in   = req_take ? req_beat : in_beat_ff;
      out_valid_in = out_load ? (fire && step_emit) : out_valid_ff;
      out_beat_in  = (out_load && fire && step_emit) ? step_result : out_beat_ff;
      state_in     = fire ? step_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_beat_ff  <= in_beat_in;
      out_beat_ff <= out_beat_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_beat_ff;

   // error results never carry a value
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_beat_ff.bad_sequence |-> out_beat_ff.code_point == '0)
      else $error("error result with nonzero code point");

   // pending count stays within a six-byte sequence
   a_pending_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_pending <= NEED_SIX_BYTE)
      else $error("pending count out of range");

   // the last byte of a string always leaves the decoder idle
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      fire && in_beat_ff.last_byte |=> state_ff == '0)
      else $error("state not cleared at end of string");

   // the last byte of a string always yields a result marked end_of_string
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      fire && in_beat_ff.last_byte |=> out_valid_ff && out_beat_ff.end_of_string)
      else $error("end of string produced no result");

endmodule
